>>> rtl/hex_bytecode_validator_core_macros.svh
// Assertion macros used by the validator core RTL.
`ifndef HEX_BYTECODE_VALIDATOR_CORE_MACROS_SVH
`define HEX_BYTECODE_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HBV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hbv_pkg.sv
// Package with the types, codes and decode functions of the hex bytecode validator.
`default_nettype none

package hbv_pkg;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_BADHEX   = 4'd1;
    localparam logic [3:0] ST_PUSH     = 4'd2;
    localparam logic [3:0] ST_STRING   = 4'd3;
    localparam logic [3:0] ST_JUMP     = 4'd4;
    localparam logic [3:0] ST_EMIT     = 4'd5;
    localparam logic [3:0] ST_CONTRACT = 4'd6;
    localparam logic [3:0] ST_TOKEN    = 4'd7;
    localparam logic [3:0] ST_MINT     = 4'd8;
    localparam logic [3:0] ST_TRANSFER = 4'd9;
    localparam logic [3:0] ST_UNKNOWN  = 4'd10;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LX    = 8'h78;
    localparam logic [7:0] CHAR_UX    = 8'h58;

    localparam logic [7:0] OP_PUSH     = 8'h01;
    localparam logic [7:0] OP_STR_A    = 8'h02;
    localparam logic [7:0] OP_STR_B    = 8'h03;
    localparam logic [7:0] OP_JUMP_A   = 8'h0D;
    localparam logic [7:0] OP_JUMP_B   = 8'h0E;
    localparam logic [7:0] OP_CONTRACT = 8'h10;
    localparam logic [7:0] OP_TOKEN    = 8'h11;
    localparam logic [7:0] OP_MINT     = 8'h12;
    localparam logic [7:0] OP_TRANSFER = 8'h13;
    localparam logic [7:0] OP_STR_C    = 8'h14;
    localparam logic [7:0] OP_EMIT     = 8'h15;
    localparam logic [7:0] OP_HALT     = 8'hFF;

    // Opcodes that are passed over without effect.
    localparam logic [7:0] OP_IGN_LO   = 8'h04;
    localparam logic [7:0] OP_IGN_HI   = 8'h0C;
    localparam logic [7:0] OP_IGN_F    = 8'h0F;

    typedef enum logic [1:0] {
        PH_OPCODE  = 2'd0,
        PH_FIXED   = 2'd1,
        PH_STRLEN  = 2'd2,
        PH_STRBODY = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OPK_KNOWN   = 2'd0,
        OPK_IGNORE  = 2'd1,
        OPK_UNKNOWN = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [3:0] cls;
        logic [2:0] nstr;
    } op_info_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
               ((c >= CHAR_LA) && (c <= CHAR_LF_HEX)) ||
               ((c >= CHAR_UA) && (c <= CHAR_UF));
    endfunction

    // Nibble value of a character already known to be a hex digit.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        if (c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
        end else if (c >= CHAR_LA) begin
            d = c - CHAR_LA + 8'd10;
        end else begin
            d = c - CHAR_UA + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic op_info_t opcode_info(input logic [7:0] b);
        op_info_t info;
        info = '{kind: OPK_KNOWN, cls: ST_OK, nstr: 3'd0};
        case (b) inside
            OP_PUSH:                      info.cls = ST_PUSH;
            OP_STR_A, OP_STR_B, OP_STR_C: begin info.cls = ST_STRING; info.nstr = 3'd1; end
            OP_JUMP_A, OP_JUMP_B:         info.cls = ST_JUMP;
            OP_EMIT:                      begin info.cls = ST_EMIT; info.nstr = 3'd1; end
            OP_CONTRACT:                  begin info.cls = ST_CONTRACT; info.nstr = 3'd3; end
            OP_TOKEN:                     begin info.cls = ST_TOKEN; info.nstr = 3'd4; end
            OP_MINT:                      begin info.cls = ST_MINT; info.nstr = 3'd2; end
            OP_TRANSFER:                  begin info.cls = ST_TRANSFER; info.nstr = 3'd3; end
            [OP_IGN_LO:OP_IGN_HI], OP_IGN_F, OP_HALT: info.kind = OPK_IGNORE;
            default:                      info.kind = OPK_UNKNOWN;
        endcase
        return info;
    endfunction

    // Fixed operand bytes that follow the strings of an instruction.
    function automatic logic [7:0] trailing_fixed(input logic [3:0] cls);
        logic [7:0] n;
        case (cls)
            ST_PUSH:     n = 8'd8;
            ST_JUMP:     n = 8'd2;
            ST_EMIT:     n = 8'd1;
            ST_TOKEN:    n = 8'd9;
            ST_MINT:     n = 8'd8;
            ST_TRANSFER: n = 8'd8;
            default:     n = 8'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hex_bytecode_validator_core.sv
// Top level of the hex bytecode validator: character intake, byte assembly and opcode checker.
//
// Usage
// -----
// The input channel (in_valid, in_ready, text_char, last) carries one ASCII
// character of a hex-text program per beat; last marks the final character.
// The output channel (out_valid, out_ready, status, program_ok) carries one
// status beat per program, produced for the beat that carried last; no beat
// is produced for any other character.
// Throughput is one character per cycle, except that a last character
// waits while a held status has not been taken. Each accepted beat is held
// in an input register, then the parse state and, on last, the result
// register are updated from it, so a status passes through both registers to out_valid.
// If the receiver stalls, the pending status is held in the result register;
// ordinary characters keep flowing, and only a further last character waits
// in the input register until the held status has been taken.
// An asynchronous reset (rst_n low) empties both registers and returns the
// parser to the start of a program; the state is also returned to that point
// after every last character, so programs may follow back to back.
`default_nettype none

`include "hex_bytecode_validator_core_macros.svh"

module hex_bytecode_validator_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_char,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [3:0]      status,
    output logic            program_ok
);

    // Input register stage.
    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       s1_advance;
    logic       s1_fire;

    // Parse state.
    logic [1:0]      char_position_reg, char_position_next;
    logic            held_zero_reg, held_zero_next;
    logic            hex_bad_reg, hex_bad_next;
    logic            nibble_pending_reg, nibble_pending_next;
    logic [3:0]      high_nibble_reg, high_nibble_next;
    logic            digit_seen_reg, digit_seen_next;
    hbv_pkg::phase_t parse_phase_reg, parse_phase_next;
    logic [3:0]      opcode_class_reg, opcode_class_next;
    logic [2:0]      strings_left_reg, strings_left_next;
    logic [7:0]      bytes_left_reg, bytes_left_next;
    logic [3:0]      parse_error_reg, parse_error_next;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic [3:0] status_reg, status_next;

    // Character-level working values.
    logic             feed_char;
    logic             inject_zero;
    logic             pend_pre;
    logic [3:0]       high_pre;
    logic             digit_pre;
    logic             byte_fire;
    logic [7:0]       byte_val;
    logic [7:0]       dec_bytes;
    logic [2:0]       dec_strings;
    hbv_pkg::op_info_t op_info;

    // A beat without last never touches the result register, so it may move
    // on even while a status waits to be taken.
    assign s1_advance = !s1_last_reg || !out_valid_reg || out_ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid) begin
            s1_char_reg <= text_char;
            s1_last_reg <= last;
        end
    end

    always_comb begin
        char_position_next  = char_position_reg;
        held_zero_next      = held_zero_reg;
        hex_bad_next        = hex_bad_reg;
        nibble_pending_next = nibble_pending_reg;
        high_nibble_next    = high_nibble_reg;
        digit_seen_next     = digit_seen_reg;
        parse_phase_next    = parse_phase_reg;
        opcode_class_next   = opcode_class_reg;
        strings_left_next   = strings_left_reg;
        bytes_left_next     = bytes_left_reg;
        parse_error_next    = parse_error_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        status_next         = status_reg;

        feed_char   = 1'b0;
        inject_zero = 1'b0;
        byte_fire   = 1'b0;
        byte_val    = 8'd0;
        dec_bytes   = bytes_left_reg - 8'd1;
        dec_strings = strings_left_reg - 3'd1;
        op_info     = hbv_pkg::opcode_info(8'd0);

        if (s1_fire) begin
            // Prefix handling: a leading zero is held back for one character.
            if (char_position_reg == 2'd0) begin
                if (s1_char_reg == hbv_pkg::CHAR_ZERO && !s1_last_reg) begin
                    held_zero_next = 1'b1;
                end else begin
                    feed_char = 1'b1;
                end
            end else if (char_position_reg == 2'd1 && held_zero_reg) begin
                held_zero_next = 1'b0;
                if (s1_char_reg != hbv_pkg::CHAR_LX && s1_char_reg != hbv_pkg::CHAR_UX) begin
                    inject_zero = 1'b1;
                    feed_char   = 1'b1;
                end
            end else begin
                feed_char = 1'b1;
            end
            if (char_position_reg != 2'd2) begin
                char_position_next = char_position_reg + 2'd1;
            end

            // The held zero, when released, is always the first digit seen.
            pend_pre  = inject_zero ? 1'b1 : nibble_pending_reg;
            high_pre  = inject_zero ? 4'd0 : high_nibble_reg;
            digit_pre = inject_zero ? 1'b1 : digit_seen_reg;
            nibble_pending_next = pend_pre;
            high_nibble_next    = high_pre;
            digit_seen_next     = digit_pre;

            if (feed_char && !hbv_pkg::is_space(s1_char_reg)) begin
                if (hbv_pkg::is_hex(s1_char_reg)) begin
                    digit_seen_next = 1'b1;
                    if (!pend_pre) begin
                        high_nibble_next    = hbv_pkg::hex_value(s1_char_reg);
                        nibble_pending_next = 1'b1;
                    end else begin
                        nibble_pending_next = 1'b0;
                        byte_fire = 1'b1;
                        byte_val  = {high_pre, hbv_pkg::hex_value(s1_char_reg)};
                    end
                end else begin
                    hex_bad_next = 1'b1;
                end
            end

            // Opcode-length checker; everything is ignored after an unknown opcode.
            if (byte_fire && parse_error_reg == hbv_pkg::ST_OK) begin
                unique case (parse_phase_reg)
                    hbv_pkg::PH_OPCODE: begin
                        op_info = hbv_pkg::opcode_info(byte_val);
                        if (op_info.kind == hbv_pkg::OPK_UNKNOWN) begin
                            parse_error_next = hbv_pkg::ST_UNKNOWN;
                        end else if (op_info.kind == hbv_pkg::OPK_KNOWN) begin
                            opcode_class_next = op_info.cls;
                            strings_left_next = op_info.nstr;
                            if (op_info.nstr != 3'd0) begin
                                parse_phase_next = hbv_pkg::PH_STRLEN;
                            end else if (hbv_pkg::trailing_fixed(op_info.cls) != 8'd0) begin
                                bytes_left_next  = hbv_pkg::trailing_fixed(op_info.cls);
                                parse_phase_next = hbv_pkg::PH_FIXED;
                            end else begin
                                parse_phase_next = hbv_pkg::PH_OPCODE;
                            end
                        end
                    end
                    hbv_pkg::PH_FIXED: begin
                        bytes_left_next = dec_bytes;
                        if (dec_bytes == 8'd0) begin
                            parse_phase_next = hbv_pkg::PH_OPCODE;
                        end
                    end
                    hbv_pkg::PH_STRLEN: begin
                        strings_left_next = dec_strings;
                        if (byte_val != 8'd0) begin
                            bytes_left_next  = byte_val;
                            parse_phase_next = hbv_pkg::PH_STRBODY;
                        end else if (dec_strings != 3'd0) begin
                            parse_phase_next = hbv_pkg::PH_STRLEN;
                        end else if (hbv_pkg::trailing_fixed(opcode_class_reg) != 8'd0) begin
                            bytes_left_next  = hbv_pkg::trailing_fixed(opcode_class_reg);
                            parse_phase_next = hbv_pkg::PH_FIXED;
                        end else begin
                            parse_phase_next = hbv_pkg::PH_OPCODE;
                        end
                    end
                    hbv_pkg::PH_STRBODY: begin
                        bytes_left_next = dec_bytes;
                        if (dec_bytes == 8'd0) begin
                            if (strings_left_reg != 3'd0) begin
                                parse_phase_next = hbv_pkg::PH_STRLEN;
                            end else if (hbv_pkg::trailing_fixed(opcode_class_reg) != 8'd0)
                            begin
                                bytes_left_next  = hbv_pkg::trailing_fixed(opcode_class_reg);
                                parse_phase_next = hbv_pkg::PH_FIXED;
                            end else begin
                                parse_phase_next = hbv_pkg::PH_OPCODE;
                            end
                        end
                    end
                    default: parse_phase_next = hbv_pkg::PH_OPCODE;
                endcase
            end

            // On the last character: rank the status, then start afresh.
            if (s1_last_reg) begin
                if (hex_bad_next || nibble_pending_next || !digit_seen_next) begin
                    status_next = hbv_pkg::ST_BADHEX;
                end else if (parse_error_next != hbv_pkg::ST_OK) begin
                    status_next = parse_error_next;
                end else if (parse_phase_next != hbv_pkg::PH_OPCODE) begin
                    status_next = opcode_class_next;
                end else begin
                    status_next = hbv_pkg::ST_OK;
                end
                out_valid_next      = 1'b1;
                char_position_next  = 2'd0;
                held_zero_next      = 1'b0;
                hex_bad_next        = 1'b0;
                nibble_pending_next = 1'b0;
                high_nibble_next    = 4'd0;
                digit_seen_next     = 1'b0;
                parse_phase_next    = hbv_pkg::PH_OPCODE;
                opcode_class_next   = 4'd0;
                strings_left_next   = 3'd0;
                bytes_left_next     = 8'd0;
                parse_error_next    = hbv_pkg::ST_OK;
            end
        end else begin
            pend_pre  = nibble_pending_reg;
            high_pre  = high_nibble_reg;
            digit_pre = digit_seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            char_position_reg  <= 2'd0;
            held_zero_reg      <= 1'b0;
            hex_bad_reg        <= 1'b0;
            nibble_pending_reg <= 1'b0;
            high_nibble_reg    <= 4'd0;
            digit_seen_reg     <= 1'b0;
            parse_phase_reg    <= hbv_pkg::PH_OPCODE;
            opcode_class_reg   <= 4'd0;
            strings_left_reg   <= 3'd0;
            bytes_left_reg     <= 8'd0;
            parse_error_reg    <= hbv_pkg::ST_OK;
            out_valid_reg      <= 1'b0;
        end else begin
            char_position_reg  <= char_position_next;
            held_zero_reg      <= held_zero_next;
            hex_bad_reg        <= hex_bad_next;
            nibble_pending_reg <= nibble_pending_next;
            high_nibble_reg    <= high_nibble_next;
            digit_seen_reg     <= digit_seen_next;
            parse_phase_reg    <= parse_phase_next;
            opcode_class_reg   <= opcode_class_next;
            strings_left_reg   <= strings_left_next;
            bytes_left_reg     <= bytes_left_next;
            parse_error_reg    <= parse_error_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        status_reg <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign program_ok = (status_reg == hbv_pkg::ST_OK);

    // A held zero only ever waits on the second character of a program.
    `HBV_ASSERT_NOW(a_held_zero_pos, clk, rst_n, held_zero_reg, char_position_reg == 2'd1,
        "held zero outside the second character position")

    // Once the last character is processed the parser is back at the start.
    `HBV_ASSERT_NEXT(a_restart, clk, rst_n, s1_fire && s1_last_reg,
        char_position_reg == 2'd0 && !nibble_pending_reg && !digit_seen_reg &&
        parse_phase_reg == hbv_pkg::PH_OPCODE && parse_error_reg == hbv_pkg::ST_OK,
        "parse state not cleared after the last character")

    // Characters other than the last never raise a status beat.
    `HBV_ASSERT_NEXT(a_no_spurious, clk, rst_n, !(s1_fire && s1_last_reg),
        out_valid_reg == $past(out_valid_reg && !out_ready),
        "status beat raised without a last character")

    // A last character never overwrites a status that is still waiting.
    `HBV_ASSERT_NOW(a_no_overwrite, clk, rst_n, s1_fire && s1_last_reg,
        !out_valid_reg || out_ready, "pending status overwritten")

endmodule

`default_nettype wire
